// ----- src/prt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_pkg
// Shared codes, state encoding and controller/datapath interface structs for
// the price trigger table.
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam logic [1:0] OP_ARM    = 2'd0;
  localparam logic [1:0] OP_DISARM = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] KIND_ARM_ACK    = 2'd0;
  localparam logic [1:0] KIND_DISARM_ACK = 2'd1;
  localparam logic [1:0] KIND_FIRED      = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic REG_SINK_ATTACHED = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ARM,
    S_DSCAN,
    S_TSCAN
  } state_t;

  typedef enum logic [2:0] {
    SEL_ARM_ACK,
    SEL_ARM_FULL,
    SEL_DIS_OK,
    SEL_DIS_NOT_FOUND,
    SEL_FIRE_MID,
    SEL_FIRE_LAST
  } out_sel_t;

  typedef struct packed {
    logic     req_load;
    logic     idx_clear;
    logic     idx_inc;
    logic     arm_write;
    logic     remove;
    logic     mark_fired;
    logic     pend_load;
    logic     pend_clear;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic scan_end;
    logic id_match;
    logic hit;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

// ----- src/prt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_ctrl
// Sequencer for arm, disarm and tick requests of the price trigger table.
// ----------------------------------------------------------------------------
module prt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     in_op,
  input  logic           sink,
  input  prt_pkg::stat_t stat,
  output logic           in_ready,
  output prt_pkg::cmd_t  cmd
);

  prt_pkg::state_t state;
  prt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      prt_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            prt_pkg::OP_ARM:    state_next = prt_pkg::S_ARM;
            prt_pkg::OP_DISARM: state_next = prt_pkg::S_DSCAN;
            prt_pkg::OP_TICK: begin
              if (sink && !stat.count_zero) begin
                state_next = prt_pkg::S_TSCAN;
              end
            end
            default: state_next = prt_pkg::S_IDLE;
          endcase
        end
      end
      prt_pkg::S_ARM: begin
        if (stat.out_free) begin
          state_next = prt_pkg::S_IDLE;
        end
      end
      prt_pkg::S_DSCAN: begin
        if ((stat.scan_end || stat.id_match) && stat.out_free) begin
          state_next = prt_pkg::S_IDLE;
        end
      end
      prt_pkg::S_TSCAN: begin
        if (stat.scan_end && (!stat.pend_valid || stat.out_free)) begin
          state_next = prt_pkg::S_IDLE;
        end
      end
      default: state_next = prt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.out_sel = prt_pkg::SEL_ARM_ACK;
    case (state)
      prt_pkg::S_IDLE: begin
        in_ready       = 1'b1;
        cmd.req_load   = in_valid;
        cmd.idx_clear  = 1'b1;
        cmd.pend_clear = 1'b1;
      end
      prt_pkg::S_ARM: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.arm_write = !stat.full;
          cmd.out_sel   = stat.full ? prt_pkg::SEL_ARM_FULL : prt_pkg::SEL_ARM_ACK;
        end
      end
      prt_pkg::S_DSCAN: begin
        if (stat.scan_end) begin
          cmd.out_load = stat.out_free;
          cmd.out_sel  = prt_pkg::SEL_DIS_NOT_FOUND;
        end else if (stat.id_match) begin
          cmd.out_load = stat.out_free;
          cmd.remove   = stat.out_free;
          cmd.out_sel  = prt_pkg::SEL_DIS_OK;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      prt_pkg::S_TSCAN: begin
        if (stat.scan_end) begin
          if (stat.pend_valid && stat.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.pend_clear = 1'b1;
            cmd.out_sel    = prt_pkg::SEL_FIRE_LAST;
          end
        end else if (stat.hit) begin
          if (!stat.pend_valid || stat.out_free) begin
            cmd.mark_fired = 1'b1;
            cmd.pend_load  = 1'b1;
            cmd.idx_inc    = 1'b1;
            cmd.out_load   = stat.pend_valid;
            cmd.out_sel    = prt_pkg::SEL_FIRE_MID;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/prt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_datapath
// Trigger slots, id counter, scan pointer, pending fire and result register.
// ----------------------------------------------------------------------------
module prt_datapath #(
  parameter int TABLE_DEPTH = 16,
  parameter int PRICE_WIDTH = 40,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  prt_pkg::cmd_t          cmd,
  output prt_pkg::stat_t         stat,
  input  logic [31:0]            in_key,
  input  logic                   in_side,
  input  logic [PRICE_WIDTH-1:0] in_price,
  input  logic [31:0]            in_tid,
  input  logic [PRICE_WIDTH-1:0] in_bid,
  input  logic [PRICE_WIDTH-1:0] in_ask,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [1:0]             out_kind,
  output logic [1:0]             out_status,
  output logic [31:0]            out_id,
  output logic [CW-1:0]          out_count,
  output logic                   out_side,
  output logic [PRICE_WIDTH-1:0] out_price,
  output logic [31:0]            out_key,
  output logic                   out_last
);

  logic [31:0]            req_key;
  logic                   req_side;
  logic [PRICE_WIDTH-1:0] req_price;
  logic [31:0]            req_tid;
  logic [PRICE_WIDTH-1:0] req_bid;
  logic [PRICE_WIDTH-1:0] req_ask;

  logic [31:0]            slot_id    [TABLE_DEPTH];
  logic [31:0]            slot_key   [TABLE_DEPTH];
  logic                   slot_side  [TABLE_DEPTH];
  logic [PRICE_WIDTH-1:0] slot_price [TABLE_DEPTH];
  logic                   slot_fired [TABLE_DEPTH];

  logic [CW-1:0]          held_count;
  logic [CW-1:0]          idx;
  logic [31:0]            next_id;

  logic                   pend_valid;
  logic [31:0]            pend_id;
  logic [31:0]            pend_key;
  logic                   pend_side;
  logic [PRICE_WIDTH-1:0] pend_price;

  logic [IW-1:0]          ridx;
  logic                   price_hit;

  assign ridx = idx[IW-1:0];

  always_comb begin
    if (slot_side[ridx] == 1'b0) begin
      price_hit = (req_ask != '0) && (req_ask <= slot_price[ridx]);
    end else begin
      price_hit = (req_bid != '0) && (req_bid >= slot_price[ridx]);
    end
  end

  assign stat.count_zero = (held_count == '0);
  assign stat.full       = (held_count == CW'(TABLE_DEPTH));
  assign stat.scan_end   = (idx == held_count);
  assign stat.id_match   = (slot_id[ridx] == req_tid);
  assign stat.hit        = !slot_fired[ridx] && (slot_key[ridx] == req_key) && price_hit;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_key   <= in_key;
      req_side  <= in_side;
      req_price <= in_price;
      req_tid   <= in_tid;
      req_bid   <= in_bid;
      req_ask   <= in_ask;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      if (cmd.arm_write && (held_count == CW'(j))) begin
        slot_id[j]    <= next_id;
        slot_key[j]   <= req_key;
        slot_side[j]  <= req_side;
        slot_price[j] <= req_price;
        slot_fired[j] <= 1'b0;
      end else if (cmd.remove && (CW'(j) >= idx) && (j < TABLE_DEPTH - 1)) begin
        slot_id[j]    <= slot_id[(j + 1) % TABLE_DEPTH];
        slot_key[j]   <= slot_key[(j + 1) % TABLE_DEPTH];
        slot_side[j]  <= slot_side[(j + 1) % TABLE_DEPTH];
        slot_price[j] <= slot_price[(j + 1) % TABLE_DEPTH];
        slot_fired[j] <= slot_fired[(j + 1) % TABLE_DEPTH];
      end else if (cmd.mark_fired && (idx == CW'(j))) begin
        slot_fired[j] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      next_id    <= 32'd1;
      idx        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.arm_write) begin
        held_count <= held_count + CW'(1);
        next_id    <= next_id + 32'd1;
      end else if (cmd.remove) begin
        held_count <= held_count - CW'(1);
      end
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (cmd.pend_load) begin
        pend_valid <= 1'b1;
      end else if (cmd.pend_clear) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_id    <= slot_id[ridx];
      pend_key   <= slot_key[ridx];
      pend_side  <= slot_side[ridx];
      pend_price <= slot_price[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= prt_pkg::STATUS_OK;
      out_count  <= held_count;
      out_side   <= 1'b0;
      out_price  <= '0;
      out_key    <= '0;
      out_last   <= 1'b1;
      case (cmd.out_sel)
        prt_pkg::SEL_ARM_ACK: begin
          out_kind  <= prt_pkg::KIND_ARM_ACK;
          out_id    <= next_id;
          out_count <= held_count + CW'(1);
        end
        prt_pkg::SEL_ARM_FULL: begin
          out_kind   <= prt_pkg::KIND_ARM_ACK;
          out_status <= prt_pkg::STATUS_FULL;
          out_id     <= '0;
        end
        prt_pkg::SEL_DIS_OK: begin
          out_kind  <= prt_pkg::KIND_DISARM_ACK;
          out_id    <= req_tid;
          out_count <= held_count - CW'(1);
        end
        prt_pkg::SEL_DIS_NOT_FOUND: begin
          out_kind   <= prt_pkg::KIND_DISARM_ACK;
          out_status <= prt_pkg::STATUS_NOT_FOUND;
          out_id     <= req_tid;
        end
        prt_pkg::SEL_FIRE_MID, prt_pkg::SEL_FIRE_LAST: begin
          out_kind  <= prt_pkg::KIND_FIRED;
          out_id    <= pend_id;
          out_side  <= pend_side;
          out_price <= pend_price;
          out_key   <= pend_key;
          out_last  <= (cmd.out_sel == prt_pkg::SEL_FIRE_LAST);
        end
        default: begin
          out_kind <= prt_pkg::KIND_ARM_ACK;
          out_id   <= '0;
        end
      endcase
    end
  end

endmodule

// ----- src/price_trigger_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_trigger_table
// Top level: stream ports, APB configuration register, controller and
// datapath of the price trigger table.
// ----------------------------------------------------------------------------
// A disarm request scans the table until the target id matches or the scan
// ends. A tick request scans the table when a sink is attached and entries
// are held, and otherwise finishes without a scan. The controller's scan
// examines one table entry per cycle while no fire waits on a stalled result
// output. One fire is held back during a tick so that the final fire can
// carry tlast, and each request is taken only after the previous one has
// finished, while its last result may still wait in the output register.
module price_trigger_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int PRICE_WIDTH = 40,
  localparam int CW    = $clog2(TABLE_DEPTH + 1),
  localparam int IN_W  = ((65 + 3 * PRICE_WIDTH) + 7) / 8 * 8,
  localparam int OUT_W = ((67 + CW + PRICE_WIDTH) + 7) / 8 * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // instrument_key, trigger_side, trigger_price, target_id, bid_price, ask_price
  input  logic [IN_W-1:0]  s_axis_tdata,
  // operation
  input  logic [1:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status, entry_id, entry_count, fired_side, fired_price, fired_key
  output logic [OUT_W-1:0] m_axis_tdata,
  // result_kind
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int SIDE_LSB  = 32;
  localparam int PRICE_LSB = 33;
  localparam int TID_LSB   = PRICE_LSB + PRICE_WIDTH;
  localparam int BID_LSB   = TID_LSB + 32;
  localparam int ASK_LSB   = BID_LSB + PRICE_WIDTH;

  prt_pkg::cmd_t  cmd;
  prt_pkg::stat_t stat;

  logic                   sink_attached;
  logic [1:0]             out_status;
  logic [31:0]            out_id;
  logic [CW-1:0]          out_count;
  logic                   out_side;
  logic [PRICE_WIDTH-1:0] out_price;
  logic [31:0]            out_key;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sink_attached <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == prt_pkg::REG_SINK_ATTACHED)) begin
      sink_attached <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == prt_pkg::REG_SINK_ATTACHED) ? {31'd0, sink_attached} : 32'd0;

  prt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .sink     (sink_attached),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  prt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PRICE_WIDTH (PRICE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_key     (s_axis_tdata[31:0]),
    .in_side    (s_axis_tdata[SIDE_LSB]),
    .in_price   (s_axis_tdata[PRICE_LSB +: PRICE_WIDTH]),
    .in_tid     (s_axis_tdata[TID_LSB +: 32]),
    .in_bid     (s_axis_tdata[BID_LSB +: PRICE_WIDTH]),
    .in_ask     (s_axis_tdata[ASK_LSB +: PRICE_WIDTH]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_kind   (m_axis_tuser),
    .out_status (out_status),
    .out_id     (out_id),
    .out_count  (out_count),
    .out_side   (out_side),
    .out_price  (out_price),
    .out_key    (out_key),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({out_key, out_price, out_side, out_count, out_id, out_status});

endmodule
